// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is checked only while out of reset.
`define PPFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PPFB_NEVER(lbl, cond, msg) \
    `PPFB_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/ppfb_pkg.sv =====
// Types and constants shared by the packed-pixel frame buffer flush block.
package ppfb_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_PULL  = 2'd3;

    // panel window commands
    localparam logic [7:0] CMD_COLUMN = 8'h2A;
    localparam logic [7:0] CMD_ROW    = 8'h2B;
    localparam logic [7:0] CMD_WRITE  = 8'h2C;
    localparam logic [7:0] COL_OFFSET = 8'h05;

    // header run: seven bytes, bit set where the byte is a parameter
    localparam int          HDR_LEN       = 7;
    localparam logic [6:0]  HDR_DATA_MASK = 7'b0110110;

    // store index width that covers every legal panel size
    localparam int IDX_W = 16;

    // divide an 8-bit value by 3: (v * 171) >> 9 is exact below 256
    localparam logic [15:0] DIV3_MUL   = 16'd171;
    localparam int          DIV3_SHIFT = 9;

    // job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] x;
        logic [9:0] y;
        logic [9:0] x_end;
        logic [9:0] y_end;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } result_t;

    // classified job: addr is the pixel byte index or the flush row base
    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] addr;
        logic [7:0]       col_a;
        logic [7:0]       col_b;
        logic [7:0]       row_a;
        logic [7:0]       row_b;
        logic [7:0]       data;
        logic             sub_x;
        logic             sub_y;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ===== rtl/ppfb_front.sv =====
// Front end: takes command words, clips and classifies them into jobs.
module ppfb_front #(
    parameter int PANEL_WIDTH  = 300,
    parameter int PANEL_HEIGHT = 400
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ppfb_pkg::cmd_t    cmd,
    input  ppfb_pkg::q_stat_t q_stat,
    input  logic              clearing,
    output logic              busy,
    output logic              push,
    output ppfb_pkg::job_t    job
);

    localparam int ROW_BYTES   = PANEL_WIDTH / 2;
    localparam int ROW_COUNT   = PANEL_HEIGHT / 2;
    localparam int STORE_DEPTH = ROW_BYTES * ROW_COUNT;
    localparam int IW          = ppfb_pkg::IDX_W;

    localparam logic [9:0]    X_LIMIT = 10'(PANEL_WIDTH);
    localparam logic [9:0]    X_LAST  = 10'(PANEL_WIDTH - 1);
    localparam logic [9:0]    Y_LIMIT = 10'(PANEL_HEIGHT);
    localparam logic [9:0]    Y_LAST  = 10'(PANEL_HEIGHT - 1);
    localparam logic [IW-1:0] RB      = IW'(ROW_BYTES);
    localparam logic [IW-1:0] DEPTH   = IW'(STORE_DEPTH);

    logic           take;
    logic           x_ok;
    logic           y_ok;
    logic [9:0]     x2c;
    logic [9:0]     y2c;
    logic [9:0]     x_lo;
    logic [9:0]     x_hi;
    logic [9:0]     y_lo;
    logic [9:0]     y_hi;
    logic [7:0]     row_sel;
    logic [IW-1:0]  row_base;
    logic [IW-1:0]  pix_idx;
    logic [15:0]    prod_lo;
    logic [15:0]    prod_hi;
    logic           keep;
    ppfb_pkg::job_t job_dec;
    logic           valid_reg;
    logic           valid_next;
    ppfb_pkg::job_t job_reg;
    ppfb_pkg::job_t job_next;

    assign push = valid_reg && !q_stat.full;
    assign busy = (valid_reg && q_stat.full) || clearing;
    assign take = start && !busy;
    assign job  = job_reg;

    always_comb
    begin
        x_ok = cmd.x < X_LIMIT;
        y_ok = cmd.y < Y_LIMIT;
        x2c  = (cmd.x_end >= X_LIMIT) ? X_LAST : cmd.x_end;
        y2c  = (cmd.y_end >= Y_LIMIT) ? Y_LAST : cmd.y_end;
        x_lo = (cmd.x > x2c) ? x2c : cmd.x;
        x_hi = (cmd.x > x2c) ? cmd.x : x2c;
        y_lo = (cmd.y > y2c) ? y2c : cmd.y;
        y_hi = (cmd.y > y2c) ? cmd.y : y2c;

        // one constant multiplier serves the pixel index and the flush row base
        row_sel  = (cmd.op == ppfb_pkg::OP_FLUSH) ? y_lo[8:1] : cmd.y[8:1];
        row_base = IW'(row_sel) * RB;
        pix_idx  = row_base + IW'(cmd.x[8:1]);

        prod_lo = 16'(x_lo[8:1]) * ppfb_pkg::DIV3_MUL;
        prod_hi = 16'(x_hi[8:1]) * ppfb_pkg::DIV3_MUL;

        job_dec.kind  = cmd.op;
        job_dec.addr  = (cmd.op == ppfb_pkg::OP_WRITE) ? pix_idx : row_base;
        job_dec.col_a = 8'(prod_lo >> ppfb_pkg::DIV3_SHIFT);
        job_dec.col_b = 8'(prod_hi >> ppfb_pkg::DIV3_SHIFT);
        job_dec.row_a = y_lo[8:1];
        job_dec.row_b = y_hi[8:1];
        job_dec.data  = cmd.value;
        job_dec.sub_x = cmd.x[0];
        job_dec.sub_y = cmd.y[0];

        unique case (cmd.op)
            ppfb_pkg::OP_WRITE: keep = x_ok && y_ok && (pix_idx < DEPTH);
            ppfb_pkg::OP_FLUSH: keep = x_ok && y_ok;
            default:            keep = 1'b1;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (take)
        begin
            valid_next = keep;
            job_next   = job_dec;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// ===== rtl/ppfb_queue.sv =====
// Two-entry job queue between the front end and the back end.
module ppfb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppfb_pkg::job_t    push_job,
    input  logic              pop,
    output ppfb_pkg::job_t    head,
    output ppfb_pkg::q_stat_t q_stat
);

    localparam int PW = ppfb_pkg::Q_PTR_W;
    localparam int CW = ppfb_pkg::Q_CNT_W;

    ppfb_pkg::job_t entry_reg [ppfb_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == CW'(0));
    assign q_stat.full  = (count_reg == CW'(ppfb_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/ppfb_back.sv =====
// Back end: frame store, pixel read-modify-write, fill sweep, header and data stream.
module ppfb_back #(
    parameter int PANEL_WIDTH  = 300,
    parameter int PANEL_HEIGHT = 400
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ppfb_pkg::job_t    head,
    input  ppfb_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              clearing,
    output logic              strobe,
    output ppfb_pkg::result_t result
);

    localparam int ROW_BYTES   = PANEL_WIDTH / 2;
    localparam int ROW_COUNT   = PANEL_HEIGHT / 2;
    localparam int STORE_DEPTH = ROW_BYTES * ROW_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IW          = ppfb_pkg::IDX_W;
    localparam int HL          = ppfb_pkg::HDR_LEN;

    localparam logic [IW-1:0]     RB         = IW'(ROW_BYTES);
    localparam logic [IW-1:0]     DEPTH      = IW'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [8:0]        BYTE_LIMIT = 9'(ROW_BYTES);
    localparam logic [8:0]        BYTE_LAST  = 9'(ROW_BYTES - 1);
    localparam logic [7:0]        GROUP_LAST = 8'((ROW_BYTES - 1) / 3);
    localparam logic [2:0]        HDR_END    = 3'(HL - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PIX_WR   = 3'd1;
    localparam logic [2:0] ST_SWEEP    = 3'd2;
    localparam logic [2:0] ST_HDR      = 3'd3;
    localparam logic [2:0] ST_PULL_OUT = 3'd4;

    logic [7:0] store_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    logic [2:0]        state_reg, state_next;
    logic              clear_reg, clear_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [7:0]        fill_val_reg, fill_val_next;
    ppfb_pkg::job_t    cur_reg, cur_next;
    logic [2:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]        hdr_first_reg, hdr_first_next;
    logic [7:0]        hdr_last_reg, hdr_last_next;
    logic [7:0]        hdr_rs_reg, hdr_rs_next;
    logic [7:0]        hdr_re_reg, hdr_re_next;
    logic              active_reg, active_next;
    logic [IW-1:0]     row_base_reg, row_base_next;
    logic [7:0]        cur_row_reg, cur_row_next;
    logic [7:0]        cur_byte_reg, cur_byte_next;
    logic [7:0]        row_last_reg, row_last_next;
    logic [7:0]        byte_first_reg, byte_first_next;
    logic [7:0]        byte_last_reg, byte_last_next;
    logic              pull_in_reg, pull_in_next;
    logic              pull_fin_reg, pull_fin_next;
    logic              strobe_reg, strobe_next;
    ppfb_pkg::result_t result_reg, result_next;

    logic [8:0]    bs;
    logic [8:0]    be_raw;
    logic [8:0]    be;
    logic [IW-1:0] p_addr;
    logic          p_in;
    logic          row_end;
    logic          fin;
    logic [2:0]    sub_pos;
    logic [2:0]    pos_hi;
    logic [2:0]    pos_lo;
    logic [7:0]    px_mask;
    logic [7:0]    px_bits;
    logic [7:0]    hdr_byte [HL];

    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign clearing = clear_reg;
    assign strobe   = strobe_reg;
    assign result   = result_reg;

    // window geometry of the queued flush job
    always_comb
    begin
        bs     = {head.col_a, 1'b0} + 9'(head.col_a);
        be_raw = {head.col_b, 1'b0} + 9'(head.col_b) + 9'd2;
        be     = (be_raw >= BYTE_LIMIT) ? BYTE_LAST : be_raw;
    end

    // next stream byte
    always_comb
    begin
        p_addr  = row_base_reg + IW'(cur_byte_reg);
        p_in    = p_addr < DEPTH;
        row_end = (cur_byte_reg == byte_last_reg);
        fin     = row_end && (cur_row_reg == row_last_reg);
    end

    // two bits of a 2x2 group
    always_comb
    begin
        sub_pos = {cur_reg.sub_x, 1'b0, cur_reg.sub_y};
        pos_hi  = 3'd7 - sub_pos;
        pos_lo  = 3'd5 - sub_pos;
        px_mask = (8'd1 << pos_hi) | (8'd1 << pos_lo);
        px_bits = (8'(cur_reg.data[1]) << pos_hi) | (8'(cur_reg.data[0]) << pos_lo);
    end

    always_comb
    begin
        hdr_byte[0] = ppfb_pkg::CMD_COLUMN;
        hdr_byte[1] = hdr_first_reg;
        hdr_byte[2] = hdr_last_reg;
        hdr_byte[3] = ppfb_pkg::CMD_ROW;
        hdr_byte[4] = hdr_rs_reg;
        hdr_byte[5] = hdr_re_reg;
        hdr_byte[6] = ppfb_pkg::CMD_WRITE;
    end

    always_comb
    begin
        state_next      = state_reg;
        clear_next      = clear_reg;
        sweep_addr_next = sweep_addr_reg;
        fill_val_next   = fill_val_reg;
        cur_next        = cur_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        hdr_first_next  = hdr_first_reg;
        hdr_last_next   = hdr_last_reg;
        hdr_rs_next     = hdr_rs_reg;
        hdr_re_next     = hdr_re_reg;
        active_next     = active_reg;
        row_base_next   = row_base_reg;
        cur_row_next    = cur_row_reg;
        cur_byte_next   = cur_byte_reg;
        row_last_next   = row_last_reg;
        byte_first_next = byte_first_reg;
        byte_last_next  = byte_last_reg;
        pull_in_next    = pull_in_reg;
        pull_fin_next   = pull_fin_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        rd_en           = 1'b0;
        rd_addr         = head.addr[ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = sweep_addr_reg;
        wr_data         = fill_val_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    unique case (head.kind)
                        ppfb_pkg::OP_WRITE:
                        begin
                            rd_en      = 1'b1;
                            cur_next   = head;
                            state_next = ST_PIX_WR;
                        end
                        ppfb_pkg::OP_FILL:
                        begin
                            sweep_addr_next = '0;
                            fill_val_next   = head.data;
                            state_next      = ST_SWEEP;
                        end
                        ppfb_pkg::OP_FLUSH:
                        begin
                            hdr_first_next  = ppfb_pkg::COL_OFFSET + head.col_a;
                            hdr_last_next   = ppfb_pkg::COL_OFFSET +
                                              ((be_raw >= BYTE_LIMIT) ? GROUP_LAST
                                                                      : head.col_b);
                            hdr_rs_next     = head.row_a;
                            hdr_re_next     = head.row_b;
                            hdr_cnt_next    = '0;
                            active_next     = (be >= bs);
                            row_base_next   = head.addr;
                            cur_row_next    = head.row_a;
                            cur_byte_next   = bs[7:0];
                            row_last_next   = head.row_b;
                            byte_first_next = bs[7:0];
                            byte_last_next  = be[7:0];
                            state_next      = ST_HDR;
                        end
                        default:
                        begin
                            if (active_reg)
                            begin
                                rd_en         = p_in;
                                rd_addr       = p_addr[ADDR_W-1:0];
                                pull_in_next  = p_in;
                                pull_fin_next = fin;
                                state_next    = ST_PULL_OUT;
                                if (fin)
                                begin
                                    active_next = 1'b0;
                                end
                                else if (row_end)
                                begin
                                    cur_byte_next = byte_first_reg;
                                    cur_row_next  = cur_row_reg + 8'd1;
                                    row_base_next = row_base_reg + RB;
                                end
                                else
                                begin
                                    cur_byte_next = cur_byte_reg + 8'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_PIX_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg.addr[ADDR_W-1:0];
                wr_data    = (rd_data_reg & ~px_mask) | px_bits;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                wr_en           = 1'b1;
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == ADDR_LAST)
                begin
                    clear_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_HDR:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = hdr_byte[hdr_cnt_reg];
                result_next.is_data  = ppfb_pkg::HDR_DATA_MASK[hdr_cnt_reg];
                result_next.last     = (hdr_cnt_reg == HDR_END);
                hdr_cnt_next         = hdr_cnt_reg + 3'd1;
                if (hdr_cnt_reg == HDR_END)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PULL_OUT:
            begin
                strobe_next          = 1'b1;
                result_next.out_byte = pull_in_reg ? rd_data_reg : 8'd0;
                result_next.is_data  = 1'b1;
                result_next.last     = pull_fin_reg;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            clear_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            fill_val_reg   <= 8'd0;
            hdr_cnt_reg    <= '0;
            active_reg     <= 1'b0;
            row_base_reg   <= '0;
            cur_row_reg    <= '0;
            cur_byte_reg   <= '0;
            row_last_reg   <= '0;
            byte_first_reg <= '0;
            byte_last_reg  <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_reg      <= clear_next;
            sweep_addr_reg <= sweep_addr_next;
            fill_val_reg   <= fill_val_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            active_reg     <= active_next;
            row_base_reg   <= row_base_next;
            cur_row_reg    <= cur_row_next;
            cur_byte_reg   <= cur_byte_next;
            row_last_reg   <= row_last_next;
            byte_first_reg <= byte_first_next;
            byte_last_reg  <= byte_last_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        hdr_first_reg <= hdr_first_next;
        hdr_last_reg  <= hdr_last_next;
        hdr_rs_reg    <= hdr_rs_next;
        hdr_re_reg    <= hdr_re_next;
        pull_in_reg   <= pull_in_next;
        pull_fin_reg  <= pull_fin_next;
        result_reg    <= result_next;
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/packed_pixel_framebuffer_flush.sv =====
// Top level of the packed-pixel frame buffer with windowed flush.
`include "assert_macros.svh"

// Frame buffer for a 2-bit-per-pixel panel; each store byte holds a 2x2
// pixel group. A word is taken when start is high and busy is low. Every
// result word is on result for exactly one cycle with strobe high and must
// be taken then: the receiver cannot hold the block off. After reset the
// store is cleared by a sweep over all (PANEL_WIDTH/2)*(PANEL_HEIGHT/2)
// bytes (30000 at the default size) with busy held high. The front end
// takes one word per cycle while busy is low into a two-entry job queue;
// busy rises only when that queue and the front register are full, or
// while the store is cleared. The back end owns the frame store and works
// one job at a time: a pixel write is a read-modify-write, a pull is a
// store read followed by the data word, an area flush sends its seven
// header words, and a fill sweeps the whole store at one byte per cycle.
// Writes outside the panel, flushes with a first corner outside it, and
// pulls with no window armed are dropped without a result.
module packed_pixel_framebuffer_flush #(
    parameter int PANEL_WIDTH  = 300,
    parameter int PANEL_HEIGHT = 400
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ppfb_pkg::cmd_t    cmd,
    output logic              strobe,
    output ppfb_pkg::result_t result
);

    ppfb_pkg::job_t    fe_job;
    ppfb_pkg::job_t    q_head;
    ppfb_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;
    logic              clearing;

    // classify and clip
    ppfb_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .q_stat   (q_stat),
        .clearing (clearing),
        .busy     (busy),
        .push     (push),
        .job      (fe_job)
    );

    // decouples front from the multi-cycle back end
    ppfb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (fe_job),
        .pop      (pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    // store, sweep, header and stream
    ppfb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_stat   (q_stat),
        .pop      (pop),
        .clearing (clearing),
        .strobe   (strobe),
        .result   (result)
    );

    // the closing write command comes right after the last row parameter
    `PPFB_ASSERT(a_hdr_tail, strobe && result.last && !result.is_data |-> $past(strobe) && $past(result.is_data), "header end not preceded by row parameter")
    // the column command is followed at once by its first parameter
    `PPFB_ASSERT(a_col_param, strobe && !result.is_data && result.out_byte == ppfb_pkg::CMD_COLUMN |=> strobe && result.is_data, "column command without parameter")
    // nothing is sent while the reset clear sweep runs
    `PPFB_NEVER(a_clear_quiet, clearing && strobe, "word sent during store clear")

endmodule

// ===== sim/ppfb_flush_checker.sv =====
// Checker for the frame buffer flush block: predicts the panel words and compares them.
`timescale 1ns / 1ps

module ppfb_flush_checker #(
    parameter int PANEL_WIDTH  = 300,
    parameter int PANEL_HEIGHT = 400
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  ppfb_pkg::cmd_t    cmd,
    input  logic              strobe,
    input  ppfb_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import ppfb_pkg::*;

    localparam int ROW_BYTES   = PANEL_WIDTH / 2;
    localparam int ROW_COUNT   = PANEL_HEIGHT / 2;
    localparam int STORE_BYTES = ROW_BYTES * ROW_COUNT;
    localparam int MAX_LINES   = 50;

    // shadow frame store and window cursor
    logic [7:0] pixel_store [STORE_BYTES];
    logic       window_armed;
    logic [7:0] cur_row;
    logic [7:0] cur_byte;
    logic [7:0] last_row;
    logic [7:0] first_byte;
    logic [7:0] last_byte;

    result_t    panel_words [$];
    result_t    oldest_word;
    int         clk_count = 0;

    task automatic log_mismatch(input string msg);
        errors++;
        if (errors <= MAX_LINES)
            $display("cycle %0d: mismatch: %s", clk_count, msg);
    endtask

    function automatic result_t word_of(input logic [7:0] b, input logic d, input logic l);
        result_t w;
        w.out_byte = b;
        w.is_data  = d;
        w.last     = l;
        return w;
    endfunction

    task automatic plot_pixel(input int x, input int y, input logic [1:0] v);
        int idx;
        int pos;
        if (x < PANEL_WIDTH && y < PANEL_HEIGHT) begin
            idx = (y / 2) * ROW_BYTES + x / 2;
            pos = 7 - ((x % 2) * 4 + y % 2);
            if (idx < STORE_BYTES) begin
                pixel_store[idx][pos]     = v[1];
                pixel_store[idx][pos - 2] = v[0];
            end
        end
    endtask

    task automatic open_window(input int x1, input int y1, input int x2, input int y2);
        int t;
        int bs;
        int be;
        int rs;
        int re;
        if (x1 < PANEL_WIDTH && y1 < PANEL_HEIGHT) begin
            if (x2 >= PANEL_WIDTH)
                x2 = PANEL_WIDTH - 1;
            if (y2 >= PANEL_HEIGHT)
                y2 = PANEL_HEIGHT - 1;
            if (x1 > x2)
            begin
                t  = x1;
                x1 = x2;
                x2 = t;
            end
            if (y1 > y2)
            begin
                t  = y1;
                y1 = y2;
                y2 = t;
            end
            // columns widened to whole 3-byte groups
            bs = ((x1 / 2) / 3) * 3;
            be = ((x2 / 2) / 3) * 3 + 2;
            if (be >= ROW_BYTES)
                be = ROW_BYTES - 1;
            rs = y1 / 2;
            re = y2 / 2;

            panel_words.push_back(word_of(CMD_COLUMN, 1'b0, 1'b0));
            panel_words.push_back(word_of(8'(COL_OFFSET + bs / 3), 1'b1, 1'b0));
            panel_words.push_back(word_of(8'(COL_OFFSET + be / 3), 1'b1, 1'b0));
            panel_words.push_back(word_of(CMD_ROW, 1'b0, 1'b0));
            panel_words.push_back(word_of(8'(rs), 1'b1, 1'b0));
            panel_words.push_back(word_of(8'(re), 1'b1, 1'b0));
            panel_words.push_back(word_of(CMD_WRITE, 1'b0, 1'b1));

            window_armed = (be >= bs);
            cur_row      = 8'(rs);
            cur_byte     = 8'(bs);
            last_row     = 8'(re);
            first_byte   = 8'(bs);
            last_byte    = 8'(be);
        end
    endtask

    task automatic next_window_byte();
        int         idx;
        logic [7:0] b;
        logic       row_end;
        logic       done;
        if (window_armed) begin
            idx     = int'(cur_row) * ROW_BYTES + int'(cur_byte);
            b       = (idx < STORE_BYTES) ? pixel_store[idx] : 8'h00;
            row_end = (cur_byte == last_byte);
            done    = row_end && (cur_row == last_row);
            panel_words.push_back(word_of(b, 1'b1, done));
            if (done)
                window_armed = 1'b0;
            else if (row_end)
            begin
                cur_byte = first_byte;
                cur_row  = cur_row + 8'd1;
            end
            else
                cur_byte = cur_byte + 8'd1;
        end
    endtask

    task automatic take_word(input cmd_t c);
        case (c.op)
            OP_WRITE: plot_pixel(c.x, c.y, c.value[1:0]);
            OP_FILL:  foreach (pixel_store[i]) pixel_store[i] = c.value;
            OP_FLUSH: open_window(c.x, c.y, c.x_end, c.y_end);
            OP_PULL:  next_window_byte();
            default:  ;
        endcase
    endtask

    always @(posedge clk)
    begin
        clk_count++;
        if (!rst_n) begin
            foreach (pixel_store[i]) pixel_store[i] = 8'h00;
            window_armed = 1'b0;
            cur_row      = 8'h00;
            cur_byte     = 8'h00;
            last_row     = 8'h00;
            first_byte   = 8'h00;
            last_byte    = 8'h00;
            panel_words.delete();
            errors       = 0;
        end
        else
        begin
            // predict first so a same-cycle answer would still find its entry
            if (start && !busy)
                take_word(cmd);
            if (strobe) begin
                if (panel_words.size() == 0)
                    log_mismatch($sformatf("word %h with nothing expected", result));
                else
                begin
                    oldest_word = panel_words.pop_front();
                    if (result.out_byte !== oldest_word.out_byte)
                        log_mismatch($sformatf("out_byte %h, expected %h",
                                               result.out_byte, oldest_word.out_byte));
                    if (result.is_data !== oldest_word.is_data)
                        log_mismatch($sformatf("is_data %b, expected %b (byte %h)",
                                               result.is_data, oldest_word.is_data,
                                               oldest_word.out_byte));
                    if (result.last !== oldest_word.last)
                        log_mismatch($sformatf("last %b, expected %b (byte %h)",
                                               result.last, oldest_word.last,
                                               oldest_word.out_byte));
                end
            end
        end
        pending = panel_words.size();
    end

endmodule

// ===== sim/packed_pixel_framebuffer_flush_test.sv =====
// Top of the frame buffer flush testbench: reset, stimulus and the verdict.
`timescale 1ns / 1ps

module packed_pixel_framebuffer_flush_test;
    import ppfb_pkg::*;

    localparam int PANEL_WIDTH  = 300;
    localparam int PANEL_HEIGHT = 400;

    // stop once this many words have had an effect on the block
    localparam int WORD_TARGET  = 400;
    // every fill costs a full store sweep, so keep them rare
    localparam int FILL_BUDGET  = 5;
    // quiet cycles after the last expected word, to catch stray output
    localparam int DRAIN_CYCLES = 200;
    // the clearing sweep and five fills take the bulk of the run; the rest is small
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic    clk    = 1'b0;
    logic    rst_n  = 1'b0;
    logic    start  = 1'b0;
    cmd_t    cmd    = '0;
    logic    busy;
    logic    strobe;
    result_t result;
    int      errors;
    int      pending;

    int      cycles  = 0;
    int      counted = 0;
    int      fills   = 0;
    bit      no_gaps = 1'b0;

    always #10 clk = ~clk;

    always @(posedge clk) cycles++;

    packed_pixel_framebuffer_flush #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .result (result)
    );

    ppfb_flush_checker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .strobe  (strobe),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    function automatic cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
                                      input int xe, input int ye, input int v);
        cmd_t w;
        w.op    = op;
        w.x     = 10'(x);
        w.y     = 10'(y);
        w.x_end = 10'(xe);
        w.y_end = 10'(ye);
        w.value = 8'(v);
        return w;
    endfunction

    // any word at all, every bit of every field random
    function automatic cmd_t random_cmd();
        return make_cmd(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // mostly back to back, sometimes a short gap, now and then a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // number of data bytes a flush word opens up; 0 when the flush is dropped
    function automatic int window_len(input cmd_t f);
        int x1;
        int y1;
        int x2;
        int y2;
        int t;
        int bs;
        int be;
        x1 = f.x;
        y1 = f.y;
        x2 = f.x_end;
        y2 = f.y_end;
        if (x1 >= PANEL_WIDTH || y1 >= PANEL_HEIGHT)
            return 0;
        if (x2 >= PANEL_WIDTH)
            x2 = PANEL_WIDTH - 1;
        if (y2 >= PANEL_HEIGHT)
            y2 = PANEL_HEIGHT - 1;
        if (x1 > x2)
        begin
            t  = x1;
            x1 = x2;
            x2 = t;
        end
        if (y1 > y2)
        begin
            t  = y1;
            y1 = y2;
            y2 = t;
        end
        bs = (x1 / 6) * 3;
        be = (x2 / 6) * 3 + 2;
        if (be >= PANEL_WIDTH / 2)
            be = PANEL_WIDTH / 2 - 1;
        return (y2 / 2 - y1 / 2 + 1) * (be - bs + 1);
    endfunction

    // start held low; cmd carries junk meanwhile, the block must ignore it
    task automatic idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= random_cmd();
        end
    endtask

    // offer one word and hold it until a rising edge sees busy low
    task automatic send(input cmd_t w, input bit counts);
        if (!no_gaps)
            idle(gap_len());
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        do
            @(posedge clk);
        while (busy);
        if (counts)
            counted++;
    endtask

    task automatic pull_words(input int n);
        repeat (n) send(make_cmd(OP_PULL, $urandom, $urandom, $urandom, $urandom,
                                 $urandom), 1'b1);
    endtask

    task automatic flush_and_pull(input cmd_t f, input int extra);
        send(f, 1'b1);
        pull_words(window_len(f));
        // pulls past the end of the window must stay silent
        repeat (extra) send(make_cmd(OP_PULL, 0, 0, 0, 0, 0), 1'b0);
    endtask

    // The common case: paint a few pixels in a small patch, flush a window
    // around it and pull the whole window. Some windows are abandoned part way,
    // some get a pixel write in the middle of the stream, some clip at the
    // right or bottom edge, and a few are wide bands that may reach the right edge.
    task automatic window_sequence();
        int   bx;
        int   by;
        int   px;
        int   py;
        int   len;
        int   cut;
        cmd_t f;
        bx = $urandom_range(0, PANEL_WIDTH - 1);
        by = $urandom_range(0, PANEL_HEIGHT - 1);
        repeat ($urandom_range(0, 6))
        begin
            px = bx + $urandom_range(0, 11);
            py = by + $urandom_range(0, 7);
            send(make_cmd(OP_WRITE, px, py, $urandom, $urandom, $urandom),
                 px < PANEL_WIDTH && py < PANEL_HEIGHT);
        end

        px = bx + $urandom_range(0, 11);
        py = by + $urandom_range(0, 7);
        if ($urandom_range(0, 19) == 0)
        begin
            // wide single band: far corner anywhere in the 10-bit range
            px = $urandom_range(0, 1023);
            py = by;
        end
        if ($urandom_range(0, 1))
            f = make_cmd(OP_FLUSH, bx, by, px, py, $urandom);
        else
            f = make_cmd(OP_FLUSH, px, py, bx, by, $urandom);
        len = window_len(f);
        send(f, len > 0);

        cut = len;
        if ($urandom_range(0, 9) == 0)
            cut = $urandom_range(0, len);
        for (int i = 0; i < cut; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                send(make_cmd(OP_WRITE, bx + $urandom_range(0, 5), by + $urandom_range(0, 3),
                              0, 0, $urandom),
                     1'b1);
            pull_words(1);
        end
        if (cut == len)
            repeat ($urandom_range(0, 1)) send(make_cmd(OP_PULL, 0, 0, 0, 0, 0), 1'b0);
    endtask

    // Fully random word; fills past the budget turn into pixel writes.
    task automatic noise_word();
        cmd_t w;
        w = random_cmd();
        if (w.op == OP_FILL && fills >= FILL_BUDGET)
            w.op = OP_WRITE;
        if (w.op == OP_FILL)
            fills++;
        send(w, w.op == OP_FILL ||
                (w.op != OP_PULL && w.x < PANEL_WIDTH && w.y < PANEL_HEIGHT));
    endtask

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int r;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        // the four pixels of one group, each value, upper value bits ignored
        send(make_cmd(OP_WRITE, 0, 0, 0, 0, 8'h03), 1'b1);
        send(make_cmd(OP_WRITE, 1, 1, 0, 0, 8'hFD), 1'b1);
        send(make_cmd(OP_WRITE, 0, 1, 0, 0, 8'h02), 1'b1);
        send(make_cmd(OP_WRITE, 1, 0, 0, 0, 8'h00), 1'b1);
        // last pixel of the panel
        send(make_cmd(OP_WRITE, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 0, 0, 8'h03), 1'b1);
        // pixels just off the panel, and the far corner of the field range
        send(make_cmd(OP_WRITE, PANEL_WIDTH, 0, 0, 0, 8'h03), 1'b0);
        send(make_cmd(OP_WRITE, 1023, 1023, 1023, 1023, 8'hFF), 1'b0);
        // pull with no window armed
        send(make_cmd(OP_PULL, 0, 0, 0, 0, 0), 1'b0);
        // flushes whose first corner is off the panel are dropped
        send(make_cmd(OP_FLUSH, PANEL_WIDTH, 0, 0, 0, 0), 1'b0);
        send(make_cmd(OP_FLUSH, 0, 1023, 0, 0, 0), 1'b0);
        // corners given in reverse order, then one pull too many
        flush_and_pull(make_cmd(OP_FLUSH, 5, 3, 0, 0, 0), 1);
        // far corner clipped to the last column and row
        flush_and_pull(make_cmd(OP_FLUSH, PANEL_WIDTH - 1, PANEL_HEIGHT - 1,
                                1023, 1023, 0), 0);
        // a full-width window cut short by a fill and a new flush
        send(make_cmd(OP_FLUSH, 0, 0, 1023, 1, 0), 1'b1);
        pull_words(1);
        send(make_cmd(OP_FILL, 0, 0, 0, 0, 8'hA5), 1'b1);
        fills++;
        flush_and_pull(make_cmd(OP_FLUSH, 0, 0, 0, 0, 0), 0);

        // --- random part ---
        while (counted < WORD_TARGET)
        begin
            // a quarter of the stretches run back to back
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                window_sequence();
            else if (r < 97 || fills >= FILL_BUDGET)
                repeat ($urandom_range(1, 4)) noise_word();
            else
            begin
                fills++;
                send(make_cmd(OP_FILL, $urandom, $urandom, $urandom, $urandom, $urandom),
                     1'b1);
            end
        end

        // lower start; by this falling edge the checker has logged the last word
        no_gaps = 1'b0;
        idle(1);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
